// File: design/dbgcard_pkg.sv
package dbgcard_pkg;

   // Control register bits
   localparam logic [7:0] SEL_GREEN = 8'h01;
   localparam logic [7:0] SEL_RIGHT = 8'h02;
   localparam logic [7:0] SEL_LEFT  = 8'h04;
   localparam logic [7:0] SEL_SPORT = 8'h20;
   localparam logic [7:0] SEL_SPCFG = 8'h40;
   localparam logic [7:0] CTL_INIT  = 8'h80;
   localparam logic [7:0] CTL_RESET = 8'hFF;
   localparam logic [7:0] SEL_ALL   = 8'h67;

   // Access kinds and register offsets
   localparam logic REQ_READ  = 1'b0;
   localparam logic REQ_WRITE = 1'b1;
   localparam logic REG_CTL   = 1'b0;
   localparam logic REG_DATA  = 1'b1;

   // Result kinds
   localparam logic KIND_RESP = 1'b0;
   localparam logic KIND_BYTE = 1'b1;

   typedef struct packed {
      logic latch_req;
      logic apply;
      logic rd_issue;
      logic load_flush;
      logic load_resp;
      logic clear_fill;
   } cmd_type;

   typedef struct packed {
      logic need_flush;
      logic flush_last;
      logic rsp_free;
   } sts_type;

endpackage

// File: design/debug_card_led_display_serial_regs_unit.sv
// Channel  Direction  Beat contents
// req      in         req_type, req_reg_sel, req_write_value
// rsp      out        rsp_result_kind, rsp_read_value, rsp_serial_byte, rsp_last,
//                     rsp_red_leds, rsp_green_leds, rsp_right_digits, rsp_left_digits
//
// An access without a serial flush steps through accept, execute and load, set by
// the controller's state sequence; the response is then held in the output register.
// A flush adds a RAM read and an output load per buffered byte, plus a return
// to execute once the store is drained; each load waits while rsp is stalled.
// Reset is synchronous and active high; the serial store holds no reset.
// A stalled rsp holds the output register; the next req beat is taken once
// the response of the current access sits in the output register.
module debug_card_led_display_serial_regs_unit #(
   parameter int BUFFER_DEPTH = 32
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic       req_type,
   input  logic       req_reg_sel,
   input  logic [7:0] req_write_value,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic       rsp_result_kind,
   output logic [7:0] rsp_read_value,
   output logic [7:0] rsp_serial_byte,
   output logic       rsp_last,
   output logic [7:0] rsp_red_leds,
   output logic [7:0] rsp_green_leds,
   output logic [7:0] rsp_right_digits,
   output logic [7:0] rsp_left_digits
);
   import dbgcard_pkg::*;

   cmd_type cmd;
   sts_type sts;

   // sequence each access: latch, flush the serial store if needed, apply, respond
   dbgcard_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .sts      (sts),
      .cmd      (cmd)
   );

   // hold the card registers, the serial store and the output register
   dbgcard_dp #(
      .BUFFER_DEPTH(BUFFER_DEPTH)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .sts             (sts),
      .req_type        (req_type),
      .req_reg_sel     (req_reg_sel),
      .req_write_value (req_write_value),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_result_kind (rsp_result_kind),
      .rsp_read_value  (rsp_read_value),
      .rsp_serial_byte (rsp_serial_byte),
      .rsp_last        (rsp_last),
      .rsp_red_leds    (rsp_red_leds),
      .rsp_green_leds  (rsp_green_leds),
      .rsp_right_digits(rsp_right_digits),
      .rsp_left_digits (rsp_left_digits)
   );

endmodule

// File: design/dbgcard_ram.sv
module dbgcard_ram #(
   parameter int WIDTH  = 8,
   parameter int DEPTH  = 32,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: design/dbgcard_ctrl.sv
module dbgcard_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  dbgcard_pkg::sts_type sts,
   output dbgcard_pkg::cmd_type cmd
);
   import dbgcard_pkg::*;

   localparam logic [2:0] ST_IDLE      = 3'd0;
   localparam logic [2:0] ST_EXEC      = 3'd1;
   localparam logic [2:0] ST_FLUSH_RD  = 3'd2;
   localparam logic [2:0] ST_FLUSH_OUT = 3'd3;
   localparam logic [2:0] ST_RESP      = 3'd4;

   logic [2:0] state_ff;
   logic [2:0] state_in;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.latch_req = 1'b1;
               state_in      = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (sts.need_flush) begin
               state_in = ST_FLUSH_RD;
            end else begin
               cmd.apply = 1'b1;
               state_in  = ST_RESP;
            end
         end
         ST_FLUSH_RD: begin
            cmd.rd_issue = 1'b1;
            state_in     = ST_FLUSH_OUT;
         end
         ST_FLUSH_OUT: begin
            if (sts.rsp_free) begin
               cmd.load_flush = 1'b1;
               if (sts.flush_last) begin
                  cmd.clear_fill = 1'b1;
                  state_in       = ST_EXEC;
               end else begin
                  state_in = ST_FLUSH_RD;
               end
            end
         end
         ST_RESP: begin
            if (sts.rsp_free) begin
               cmd.load_resp = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // a drained buffer always returns to re-evaluate the access
   a_clear_to_exec: assert property (@(posedge clock) disable iff (reset)
      cmd.clear_fill |=> state_ff == ST_EXEC)
      else $error("flush end did not return to exec");

   // a new request is only taken with the previous response issued
   a_accept_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.latch_req |-> $past(state_ff) == ST_RESP || $past(state_ff) == ST_IDLE
                     || $past(reset))
      else $error("request accepted mid access");

endmodule

// File: design/dbgcard_dp.sv
module dbgcard_dp #(
   parameter int BUFFER_DEPTH = 32
) (
   input  logic                 clock,
   input  logic                 reset,
   input  dbgcard_pkg::cmd_type cmd,
   output dbgcard_pkg::sts_type sts,
   input  logic                 req_type,
   input  logic                 req_reg_sel,
   input  logic [7:0]           req_write_value,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic                 rsp_result_kind,
   output logic [7:0]           rsp_read_value,
   output logic [7:0]           rsp_serial_byte,
   output logic                 rsp_last,
   output logic [7:0]           rsp_red_leds,
   output logic [7:0]           rsp_green_leds,
   output logic [7:0]           rsp_right_digits,
   output logic [7:0]           rsp_left_digits
);
   import dbgcard_pkg::*;

   localparam int AddrW = $clog2(BUFFER_DEPTH);
   localparam logic [AddrW-1:0] FillMax = AddrW'(BUFFER_DEPTH - 1);

   // latched request
   logic       type_ff;
   logic       sel_ff;
   logic [7:0] wval_ff;

   // card state
   logic [7:0] ctl_ff, ctl_in;
   logic [7:0] last_data_ff, last_data_in;
   logic [7:0] red_ff, red_in;
   logic [7:0] green_ff, green_in;
   logic [7:0] right_ff, right_in;
   logic [7:0] left_ff, left_in;
   logic [7:0] spcfg_ff, spcfg_in;
   logic [AddrW-1:0] fill_ff, fill_in;
   logic [AddrW-1:0] ptr_ff, ptr_in;

   // output register
   logic       out_valid_ff;
   logic       out_kind_ff;
   logic [7:0] out_rd_ff;
   logic [7:0] out_sb_ff;
   logic       out_last_ff;
   logic [7:0] out_red_ff, out_green_ff, out_right_ff, out_left_ff;

   logic       is_ctl_wr, is_dat_wr, is_init, is_reset_wr;
   logic       sport_sel, route_serial, ram_wr;
   logic [7:0] pick;
   logic [7:0] rd_value;
   logic [7:0] ram_rdata;

   assign is_ctl_wr    = (type_ff == REQ_WRITE) && (sel_ff == REG_CTL);
   assign is_dat_wr    = (type_ff == REQ_WRITE) && (sel_ff == REG_DATA);
   assign is_init      = (ctl_ff & CTL_INIT) != 8'h00;
   assign is_reset_wr  = is_ctl_wr && (wval_ff == CTL_RESET);
   assign sport_sel    = (ctl_ff & SEL_SPORT) != 8'h00;
   assign route_serial = ((ctl_ff & SEL_SPCFG) == 8'h00) && sport_sel;
   assign ram_wr       = cmd.apply && is_dat_wr && is_init && route_serial;

   always_comb begin
      if ((wval_ff & SEL_SPCFG) != 8'h00)      pick = SEL_SPCFG;
      else if ((wval_ff & SEL_SPORT) != 8'h00) pick = SEL_SPORT;
      else if ((wval_ff & SEL_LEFT) != 8'h00)  pick = SEL_LEFT;
      else if ((wval_ff & SEL_RIGHT) != 8'h00) pick = SEL_RIGHT;
      else if ((wval_ff & SEL_GREEN) != 8'h00) pick = SEL_GREEN;
      else                                     pick = 8'h00;
   end

   always_comb begin
      sts.need_flush =
         (is_ctl_wr && !is_reset_wr && is_init && sport_sel
          && ((wval_ff & SEL_SPORT) == 8'h00) && (fill_ff != '0))
         || (is_dat_wr && is_init && route_serial && (fill_ff >= FillMax));
      sts.flush_last = ptr_ff == (fill_ff - AddrW'(1));
      sts.rsp_free   = !out_valid_ff || rsp_ready;
   end

   always_comb begin
      if (type_ff == REQ_WRITE)             rd_value = 8'h00;
      else if (!is_init)                    rd_value = 8'hFF;
      else if (sel_ff == REG_CTL)           rd_value = ctl_ff;
      else if ((ctl_ff & SEL_SPCFG) != 8'h00) rd_value = spcfg_ff;
      else if (sport_sel)                   rd_value = 8'h00;
      else                                  rd_value = last_data_ff;
   end

   // apply the access to the card state
   always_comb begin
      ctl_in       = ctl_ff;
      last_data_in = last_data_ff;
      red_in       = red_ff;
      green_in     = green_ff;
      right_in     = right_ff;
      left_in      = left_ff;
      spcfg_in     = spcfg_ff;
      fill_in      = fill_ff;
      if (cmd.clear_fill) begin
         fill_in = '0;
      end
      if (cmd.apply) begin
         if (is_reset_wr) begin
            ctl_in       = CTL_INIT;
            last_data_in = 8'h00;
            red_in       = 8'h00;
            green_in     = 8'h00;
            right_in     = 8'h00;
            left_in      = 8'h00;
            spcfg_in     = 8'h00;
            fill_in      = '0;
         end else if (is_ctl_wr && is_init) begin
            ctl_in = (ctl_ff & ~SEL_ALL) | pick;
         end else if (is_dat_wr && is_init) begin
            last_data_in = wval_ff;
            if ((ctl_ff & SEL_SPCFG) != 8'h00) begin
               spcfg_in = wval_ff;
            end else if (sport_sel) begin
               fill_in = fill_ff + AddrW'(1);
            end else if ((ctl_ff & SEL_LEFT) != 8'h00) begin
               left_in = wval_ff;
            end else if ((ctl_ff & SEL_RIGHT) != 8'h00) begin
               right_in = wval_ff;
            end else if ((ctl_ff & SEL_GREEN) != 8'h00) begin
               green_in = wval_ff;
            end else begin
               red_in = wval_ff;
            end
         end
      end
   end

   always_comb begin
      ptr_in = ptr_ff;
      if (cmd.latch_req || cmd.clear_fill) begin
         ptr_in = '0;
      end else if (cmd.load_flush) begin
         ptr_in = ptr_ff + AddrW'(1);
      end
   end

   dbgcard_ram #(
      .WIDTH (8),
      .DEPTH (BUFFER_DEPTH),
      .ADDR_W(AddrW)
   ) u_store (
      .clock  (clock),
      .wr_en  (ram_wr),
      .wr_addr(fill_ff),
      .wr_data(wval_ff),
      .rd_en  (cmd.rd_issue),
      .rd_addr(ptr_ff),
      .rd_data(ram_rdata)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff       <= CTL_INIT;
         last_data_ff <= 8'h00;
         red_ff       <= 8'h00;
         green_ff     <= 8'h00;
         right_ff     <= 8'h00;
         left_ff      <= 8'h00;
         spcfg_ff     <= 8'h00;
         fill_ff      <= '0;
         ptr_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         ctl_ff       <= ctl_in;
         last_data_ff <= last_data_in;
         red_ff       <= red_in;
         green_ff     <= green_in;
         right_ff     <= right_in;
         left_ff      <= left_in;
         spcfg_ff     <= spcfg_in;
         fill_ff      <= fill_in;
         ptr_ff       <= ptr_in;
         if (cmd.load_flush || cmd.load_resp) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.latch_req) begin
         type_ff <= req_type;
         sel_ff  <= req_reg_sel;
         wval_ff <= req_write_value;
      end
      if (cmd.load_flush || cmd.load_resp) begin
         out_kind_ff  <= cmd.load_flush ? KIND_BYTE : KIND_RESP;
         out_rd_ff    <= cmd.load_flush ? 8'h00 : rd_value;
         out_sb_ff    <= cmd.load_flush ? ram_rdata : 8'h00;
         out_last_ff  <= cmd.load_resp;
         out_red_ff   <= red_ff;
         out_green_ff <= green_ff;
         out_right_ff <= right_ff;
         out_left_ff  <= left_ff;
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_result_kind  = out_kind_ff;
   assign rsp_read_value   = out_rd_ff;
   assign rsp_serial_byte  = out_sb_ff;
   assign rsp_last         = out_last_ff;
   assign rsp_red_leds     = out_red_ff;
   assign rsp_green_leds   = out_green_ff;
   assign rsp_right_digits = out_right_ff;
   assign rsp_left_digits  = out_left_ff;

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= FillMax)
      else $error("serial fill overran the buffer");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (cmd.load_flush || cmd.load_resp) |-> !(out_valid_ff && !rsp_ready))
      else $error("output register overwritten while held");

   a_byte_not_last: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_kind_ff == KIND_BYTE) |-> !out_last_ff)
      else $error("flushed byte marked last");

   a_ptr_in_fill: assert property (@(posedge clock) disable iff (reset)
      cmd.rd_issue |-> ptr_ff < fill_ff)
      else $error("flush read beyond stored bytes");

endmodule

// File: tb/testbench.sv
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import dbgcard_pkg::*;

   // Serial store depth handed to the card; a flush streams at most depth-1 bytes.
   localparam int STORE_DEPTH = 32;
   // Cycles with no beat on either channel before the run is declared hung.
   localparam int WATCHDOG_LIMIT = 2000;
   // Settle time after the last expected beat: a full flush plus the access itself.
   localparam int SETTLE_CYCLES = 2 * STORE_DEPTH + 16;
   localparam int RANDOM_ACCESSES = 230;

   // One bus access waiting to be driven. Set drain to hold the access back until
   // every predicted beat has come out. Set quiet to run without idle cycles.
   typedef struct {
      logic       wr;
      logic       sel;
      logic [7:0] val;
      bit         drain;
      bit         quiet;
   } access_type;

   // One result beat as the card should present it.
   typedef struct {
      logic       kind;
      logic [7:0] rd;
      logic [7:0] sb;
      logic       last;
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] rseg;
      logic [7:0] lseg;
   } card_beat_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_ready;
   logic       req_type = 1'b0;
   logic       req_reg_sel = 1'b0;
   logic [7:0] req_write_value = 8'h00;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   logic       rsp_result_kind;
   logic [7:0] rsp_read_value;
   logic [7:0] rsp_serial_byte;
   logic       rsp_last;
   logic [7:0] rsp_red_leds;
   logic [7:0] rsp_green_leds;
   logic [7:0] rsp_right_digits;
   logic [7:0] rsp_left_digits;

   debug_card_led_display_serial_regs_unit #(
      .BUFFER_DEPTH(STORE_DEPTH)
   ) uut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_type(req_type),
      .req_reg_sel(req_reg_sel),
      .req_write_value(req_write_value),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_result_kind(rsp_result_kind),
      .rsp_read_value(rsp_read_value),
      .rsp_serial_byte(rsp_serial_byte),
      .rsp_last(rsp_last),
      .rsp_red_leds(rsp_red_leds),
      .rsp_green_leds(rsp_green_leds),
      .rsp_right_digits(rsp_right_digits),
      .rsp_left_digits(rsp_left_digits)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   // ---------------------------------------------------------------------------
   // Card predictor: its own copy of the card state, starting at reset values.
   // ---------------------------------------------------------------------------
   logic [7:0] card_ctl = CTL_INIT;
   logic [7:0] card_last = 8'h00;
   logic [7:0] card_red = 8'h00;
   logic [7:0] card_green = 8'h00;
   logic [7:0] card_rseg = 8'h00;
   logic [7:0] card_lseg = 8'h00;
   logic [7:0] card_spcfg = 8'h00;
   logic [7:0] card_store [STORE_DEPTH];
   int         store_fill = 0;

   access_type    access_q[$];
   card_beat_type card_beats[$];

   int  predicted_beats = 0;   // beats pushed by the predictor (driver side only)
   int  beats_checked = 0;     // beats popped by the monitor (nonblocking only)
   int  accesses_done = 0;
   int  flushed_bytes = 0;
   int  full_resets = 0;
   int  errors = 0;
   int  idle_cycles = 0;
   int  gap_left = 0;
   int  hold_left = 0;
   bit  quiet = 1'b0;

   // Queue one beat; display fields reflect the card state at this point.
   function automatic void push_beat(logic kind, logic [7:0] rd, logic [7:0] sb,
                                     logic last);
      card_beat_type b;
      b.kind  = kind;
      b.rd    = rd;
      b.sb    = sb;
      b.last  = last;
      b.red   = card_red;
      b.green = card_green;
      b.rseg  = card_rseg;
      b.lseg  = card_lseg;
      card_beats.push_back(b);
      predicted_beats++;
   endfunction

   // Stream the buffered serial bytes, oldest first, and empty the store.
   function automatic void drain_store();
      for (int i = 0; i < store_fill; i++)
         push_beat(KIND_BYTE, 8'h00, card_store[i], 1'b0);
      store_fill = 0;
   endfunction

   // Apply one access to the predicted card and queue every beat it causes.
   function automatic void card_access(logic wr, logic sel, logic [7:0] v);
      logic [7:0] rd;
      logic [7:0] pick;
      rd = 8'h00;
      if (wr == REQ_WRITE) begin
         if (sel == REG_CTL) begin
            if (v == CTL_RESET) begin
               // Full reset: clear everything and drop the buffer silently.
               card_last  = 8'h00;
               card_red   = 8'h00;
               card_green = 8'h00;
               card_rseg  = 8'h00;
               card_lseg  = 8'h00;
               card_spcfg = 8'h00;
               store_fill = 0;
               card_ctl   = CTL_INIT;
               full_resets++;
            end else if ((card_ctl & CTL_INIT) != 8'h00) begin
               // Leaving the serial port flushes, unless the new value keeps it set.
               if ((card_ctl & SEL_SPORT) != 8'h00 && (v & SEL_SPORT) == 8'h00)
                  drain_store();
               if ((v & SEL_SPCFG) != 8'h00)      pick = SEL_SPCFG;
               else if ((v & SEL_SPORT) != 8'h00) pick = SEL_SPORT;
               else if ((v & SEL_LEFT) != 8'h00)  pick = SEL_LEFT;
               else if ((v & SEL_RIGHT) != 8'h00) pick = SEL_RIGHT;
               else if ((v & SEL_GREEN) != 8'h00) pick = SEL_GREEN;
               else                               pick = 8'h00;
               card_ctl = (card_ctl & ~SEL_ALL) | pick;
            end
         end else if ((card_ctl & CTL_INIT) != 8'h00) begin
            card_last = v;
            if ((card_ctl & SEL_SPCFG) != 8'h00) begin
               card_spcfg = v;
            end else if ((card_ctl & SEL_SPORT) != 8'h00) begin
               // A store one short of full flushes before taking the new byte.
               if (store_fill >= STORE_DEPTH - 1)
                  drain_store();
               card_store[store_fill] = v;
               store_fill++;
            end else if ((card_ctl & SEL_LEFT) != 8'h00) begin
               card_lseg = v;
            end else if ((card_ctl & SEL_RIGHT) != 8'h00) begin
               card_rseg = v;
            end else if ((card_ctl & SEL_GREEN) != 8'h00) begin
               card_green = v;
            end else begin
               card_red = v;
            end
         end
      end else if ((card_ctl & CTL_INIT) == 8'h00) begin
         rd = 8'hFF;
      end else if (sel == REG_CTL) begin
         rd = card_ctl;
      end else if ((card_ctl & SEL_SPCFG) != 8'h00) begin
         rd = card_spcfg;
      end else if ((card_ctl & SEL_SPORT) != 8'h00) begin
         rd = 8'h00;
      end else begin
         rd = card_last;
      end
      push_beat(KIND_RESP, rd, 8'h00, 1'b1);
   endfunction

   function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch: expected %02h, got %02h", $time, name, want, got);
         errors++;
      end
   endfunction

   function automatic void add_access(logic wr, logic sel, logic [7:0] val,
                                      bit drain, bit calm);
      access_type a;
      a.wr    = wr;
      a.sel   = sel;
      a.val   = val;
      a.drain = drain;
      a.quiet = calm;
      access_q.push_back(a);
   endfunction

   // ---------------------------------------------------------------------------
   // Request driver: present pending accesses, predict each beat as it is taken.
   // ---------------------------------------------------------------------------
   always @(posedge clock) begin : req_driver
      access_type nxt;
      logic       busy;
      if (reset) begin
         req_valid <= 1'b0;
         gap_left = 0;
      end else begin
         busy = req_valid;
         if (req_valid && req_ready) begin
            card_access(req_type, req_reg_sel, req_write_value);
            accesses_done++;
            busy = 1'b0;
            gap_left = quiet ? 0 : $urandom_range(0, 4);
         end
         if (!busy) begin
            // Idle out the drawn gap, then advance unless a drain point holds us.
            if (gap_left != 0) begin
               gap_left--;
            end else if (access_q.size() != 0 &&
                         !(access_q[0].drain && beats_checked != predicted_beats)) begin
               nxt = access_q.pop_front();
               req_type        <= nxt.wr;
               req_reg_sel     <= nxt.sel;
               req_write_value <= nxt.val;
               quiet           <= nxt.quiet;
               busy = 1'b1;
            end
         end
         // Single assignment per edge so valid never drops and rises in one step.
         req_valid <= busy;
      end
   end

   // ---------------------------------------------------------------------------
   // Response monitor: check every beat against the oldest prediction.
   // ---------------------------------------------------------------------------
   always @(posedge clock) begin : rsp_monitor
      card_beat_type want;
      int            stall;
      if (reset) begin
         rsp_ready <= 1'b0;
         hold_left = 0;
      end else if (rsp_valid && rsp_ready) begin
         if (card_beats.size() == 0) begin
            $display("%0t: unexpected beat: expected none, got kind %0b read %02h byte %02h",
                     $time, rsp_result_kind, rsp_read_value, rsp_serial_byte);
            errors++;
         end else begin
            want = card_beats.pop_front();
            check_field("result_kind", 8'(want.kind), 8'(rsp_result_kind));
            check_field("read_value", want.rd, rsp_read_value);
            check_field("serial_byte", want.sb, rsp_serial_byte);
            check_field("last", 8'(want.last), 8'(rsp_last));
            check_field("red_leds", want.red, rsp_red_leds);
            check_field("green_leds", want.green, rsp_green_leds);
            check_field("right_digits", want.rseg, rsp_right_digits);
            check_field("left_digits", want.lseg, rsp_left_digits);
            beats_checked <= beats_checked + 1;
         end
         if (rsp_result_kind == KIND_BYTE)
            flushed_bytes++;
         // Draw the stall that follows this beat.
         stall = quiet ? 0 : $urandom_range(0, 4);
         hold_left = stall;
         rsp_ready <= (stall == 0);
      end else if (!rsp_ready) begin
         if (hold_left > 1) begin
            hold_left--;
         end else begin
            hold_left = 0;
            rsp_ready <= 1'b1;
         end
      end
   end

   // Watchdog: any beat on either channel restarts the count.
   always @(posedge clock) begin : watchdog
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t: no beat for %0d cycles", $time, idle_cycles);
         $display("tb: failure");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // ---------------------------------------------------------------------------
   // Stimulus: directed accesses, then random sequences, then the wrap-up.
   // ---------------------------------------------------------------------------
   initial begin : stimulus
      int         total;
      int         n;
      int         writes;
      int         pick;
      bit         calm;
      bit         long_done;
      bit         drain;
      logic [7:0] v;

      long_done = 1'b0;

      // Reset values, then every target in turn.
      add_access(REQ_READ,  REG_CTL,  8'h00, 1'b0, 1'b0);
      add_access(REQ_READ,  REG_DATA, 8'h00, 1'b0, 1'b0);
      add_access(REQ_WRITE, REG_DATA, 8'hFF, 1'b0, 1'b0);   // red by default
      add_access(REQ_WRITE, REG_DATA, 8'h00, 1'b0, 1'b0);
      add_access(REQ_WRITE, REG_CTL,  SEL_GREEN, 1'b0, 1'b0);
      add_access(REQ_WRITE, REG_DATA, 8'hA5, 1'b0, 1'b0);
      add_access(REQ_WRITE, REG_CTL,  SEL_RIGHT, 1'b0, 1'b0);
      add_access(REQ_WRITE, REG_DATA, 8'h5A, 1'b0, 1'b0);
      add_access(REQ_WRITE, REG_CTL,  SEL_LEFT, 1'b0, 1'b0);
      add_access(REQ_WRITE, REG_DATA, 8'hFF, 1'b0, 1'b0);
      add_access(REQ_READ,  REG_DATA, 8'h00, 1'b0, 1'b0);   // last data byte
      add_access(REQ_WRITE, REG_CTL,  SEL_SPCFG, 1'b0, 1'b0);
      add_access(REQ_WRITE, REG_DATA, 8'h3C, 1'b0, 1'b0);
      add_access(REQ_READ,  REG_DATA, 8'h00, 1'b0, 1'b0);   // serial config
      // Serial port: buffer bytes, read back zero, then keep the buffer across
      // a value that sets both serial bits, and flush on a real deselect.
      add_access(REQ_WRITE, REG_CTL,  SEL_SPORT, 1'b0, 1'b0);
      add_access(REQ_WRITE, REG_DATA, 8'h11, 1'b0, 1'b0);
      add_access(REQ_WRITE, REG_DATA, 8'h80, 1'b0, 1'b0);
      add_access(REQ_READ,  REG_DATA, 8'h00, 1'b0, 1'b0);
      add_access(REQ_WRITE, REG_CTL,  SEL_SPCFG | SEL_SPORT, 1'b0, 1'b0);
      add_access(REQ_READ,  REG_DATA, 8'h00, 1'b0, 1'b0);
      add_access(REQ_WRITE, REG_CTL,  SEL_SPORT, 1'b0, 1'b0);
      add_access(REQ_WRITE, REG_DATA, 8'h7E, 1'b0, 1'b0);
      add_access(REQ_WRITE, REG_CTL,  8'h9B, 1'b0, 1'b0);   // deselect, pick right
      add_access(REQ_WRITE, REG_CTL,  CTL_RESET, 1'b0, 1'b0);
      add_access(REQ_READ,  REG_CTL,  8'h00, 1'b0, 1'b0);

      total = access_q.size() + RANDOM_ACCESSES;
      drain = 1'b1;   // hold the first random access until the card is drained
      while (access_q.size() < total) begin
         calm = ($urandom_range(0, 3) == 0);
         pick = $urandom_range(0, 9);
         if (pick <= 4) begin
            // Serial session: select the port, stream bytes, then close it or leave it open.
            v = (8'($urandom) & ~SEL_SPCFG) | SEL_SPORT;
            add_access(REQ_WRITE, REG_CTL, v, drain, calm);
            if (!long_done || $urandom_range(0, 3) == 0) begin
               n = $urandom_range(STORE_DEPTH - 1, STORE_DEPTH + 8);
               long_done = 1'b1;
            end else begin
               n = $urandom_range(1, 12);
            end
            writes = 0;
            while (writes < n) begin
               if ($urandom_range(0, 5) == 0) begin
                  add_access(REQ_READ, 1'($urandom), 8'($urandom), 1'b0, calm);
               end else begin
                  add_access(REQ_WRITE, REG_DATA, 8'($urandom), 1'b0, calm);
                  writes++;
               end
            end
            case ($urandom_range(0, 5))
               0: begin
                  add_access(REQ_WRITE, REG_CTL, CTL_RESET, 1'b0, calm);
               end
               1: begin
                  add_access(REQ_WRITE, REG_CTL, 8'($urandom) | SEL_SPCFG | SEL_SPORT,
                             1'b0, calm);
               end
               5: begin
                  // leave the session open
               end
               default: begin
                  add_access(REQ_WRITE, REG_CTL, 8'($urandom) & ~SEL_SPORT, 1'b0, calm);
               end
            endcase
         end else if (pick <= 7) begin
            // Display session: pick a target, then write and read a few bytes.
            add_access(REQ_WRITE, REG_CTL, 8'($urandom), drain, calm);
            n = $urandom_range(1, 5);
            for (int i = 0; i < n; i++)
               add_access(1'($urandom), 1'($urandom), 8'($urandom), 1'b0, calm);
         end else begin
            // Noise: arbitrary accesses, extremes favored.
            n = $urandom_range(1, 4);
            for (int i = 0; i < n; i++) begin
               if ($urandom_range(0, 3) == 0)
                  v = $urandom_range(0, 1) ? 8'hFF : 8'h00;
               else
                  v = 8'($urandom);
               add_access(1'($urandom), 1'($urandom), v, (i == 0) && drain, calm);
            end
         end
         drain = ($urandom_range(0, 9) == 0);
      end
      total = access_q.size();

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Wait for every access to be taken, then for every predicted beat.
      while (accesses_done < total) @(posedge clock);
      while (card_beats.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("run covered %0d accesses and %0d result beats, %0d of them flushed bytes",
               accesses_done, predicted_beats, flushed_bytes);
      $display("full resets issued: %0d, mismatches: %0d", full_resets, errors);
      if (errors == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule
